// ----- rtl/core/tdma_pkg.sv -----
package tdma_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int POS_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = 16 + CNT_W;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_RESUME = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;  // ignored, shows current levels

   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_TMO    = 2'd1;
   localparam logic [1:0] ERR_SENS   = 2'd2;
   localparam logic [1:0] ERR_ACTIVE = 2'd3;

   localparam logic [1:0] CSR_SENS   = 2'd0;
   localparam logic [1:0] CSR_TMO    = 2'd1;
   localparam logic [1:0] CSR_HOLD   = 2'd2;
   localparam logic [1:0] CSR_UNUSED = 2'd3;  // no register, writes ignored

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture request word
      logic copy;      // copy one baseline entry into probe
      logic bpush;     // push sample into baseline window
      logic ppush;     // push sample into probe window
      logic div_start; // start both average divides
      logic div_step;  // one divide iteration
      logic finish;    // update session state, build response
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       start_ok;
      logic       bpush_ok;
      logic       ppush_ok;
      logic       copy_last;
      logic       div_last;
   } stat_type;

endpackage

// ----- rtl/core/touch_detect_moving_average_core.sv -----
// Touch detector with baseline and probe moving averages.
// Each accepted word is decoded; then a sample tick runs the divide, a valid start the window copy,
// and the response is built. One word in flight; next word accepted the cycle after the rsp handshake.
// Rate is set by the bit-serial average divider and the one-entry-a-cycle window copy.
// Synchronous active-high reset clears the baseline window, sums and session state; hold_ticks = 1.
module touch_detect_moving_average_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic        req_data_ready,
   input  logic [15:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_trigger,
   output logic        rsp_power_enable,
   output logic        rsp_session_active,
   output logic        rsp_session_done,
   output logic        rsp_touch_found,
   output logic [15:0] rsp_last_value,
   output logic [15:0] rsp_baseline_avg,
   output logic [1:0]  rsp_start_error,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   tdma_pkg::cmd_type  cmd;
   tdma_pkg::stat_type stat;

   tdma_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .cmd(cmd)
   );

   tdma_dp u_dp (
      .clock(clock), .reset(reset),
      .req_op(req_op), .req_data_ready(req_data_ready), .req_sample(req_sample),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .stat(stat),
      .rsp_trigger(rsp_trigger), .rsp_power_enable(rsp_power_enable),
      .rsp_session_active(rsp_session_active), .rsp_session_done(rsp_session_done),
      .rsp_touch_found(rsp_touch_found), .rsp_last_value(rsp_last_value),
      .rsp_baseline_avg(rsp_baseline_avg), .rsp_start_error(rsp_start_error)
   );

endmodule

// ----- rtl/core/tdma_ctrl.sv -----
module tdma_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  tdma_pkg::stat_type stat,
   output tdma_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DEC  = 6'b000010,
      ST_COPY = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_RSP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (stat.op == tdma_pkg::OP_START && stat.start_ok) begin
               state_in = ST_COPY;
            end else if (stat.op == tdma_pkg::OP_SAMPLE) begin
               cmd.bpush = stat.bpush_ok;
               cmd.ppush = stat.ppush_ok;
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (stat.copy_last) state_in = ST_FIN;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_fin_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish not followed by response");
   a_load_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DEC) else $error("load without decode");
`endif

endmodule

// ----- rtl/core/tdma_dp.sv -----
module tdma_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_op,
   input  logic               req_data_ready,
   input  logic [15:0]        req_sample,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  tdma_pkg::cmd_type  cmd,
   output tdma_pkg::stat_type stat,
   output logic               rsp_trigger,
   output logic               rsp_power_enable,
   output logic               rsp_session_active,
   output logic               rsp_session_done,
   output logic               rsp_touch_found,
   output logic [15:0]        rsp_last_value,
   output logic [15:0]        rsp_baseline_avg,
   output logic [1:0]         rsp_start_error
);

   localparam int PW = tdma_pkg::POS_W;
   localparam int CW = tdma_pkg::CNT_W;
   localparam int SW = tdma_pkg::SUM_W;
   localparam int DEPTH = tdma_pkg::WINDOW_DEPTH;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [PW-1:0] POS_MAX = PW'(DEPTH - 1);
   localparam int DIV_STEPS = SW;
   localparam int DCW = $clog2(DIV_STEPS + 1);

   // config registers
   logic [15:0] sens_ff, hold_cfg_ff;
   logic [31:0] tmo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff <= '0;
         tmo_ff <= '0;
         hold_cfg_ff <= 16'd1;
      end else if (csr_write) begin
         case (csr_index)
            tdma_pkg::CSR_SENS: sens_ff <= csr_data[15:0];
            tdma_pkg::CSR_TMO:  tmo_ff <= csr_data;
            tdma_pkg::CSR_HOLD: hold_cfg_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // request word
   logic [1:0]  op_ff;
   logic        rdy_ff;
   logic [15:0] smp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         rdy_ff <= req_data_ready;
         smp_ff <= req_sample;
      end
   end

   // session state
   logic          brun_ff, active_ff, trig_ff, pwr_ff;
   logic [31:0]   ticks_ff;
   logic [15:0]   hold_ff;
   logic [SW-1:0] bsum_ff, psum_ff;
   logic [CW-1:0] bcnt_ff, pcnt_ff;
   logic [PW-1:0] bpos_ff, ppos_ff, cpos_ff;
   logic [15:0]   bwin_ff [DEPTH];
   logic [15:0]   pwin_ff [DEPTH];

   logic [1:0] err;
   always_comb begin
      if (tmo_ff == '0) err = tdma_pkg::ERR_TMO;
      else if (sens_ff == '0) err = tdma_pkg::ERR_SENS;
      else if (active_ff) err = tdma_pkg::ERR_ACTIVE;
      else err = tdma_pkg::ERR_OK;
   end

   logic sess;
   assign sess = active_ff && (ticks_ff != '0);

   assign stat.op = op_ff;
   assign stat.start_ok = (err == tdma_pkg::ERR_OK);
   assign stat.bpush_ok = brun_ff && !active_ff && rdy_ff;
   assign stat.ppush_ok = sess && rdy_ff;
   assign stat.copy_last = (cpos_ff == POS_MAX);

   // serial dividers for both averages
   logic [DCW-1:0] dcnt_ff;
   logic [SW-1:0]  bq_ff, pq_ff;
   logic [CW:0]    br_ff, pr_ff;
   logic [CW:0]    br_sh, pr_sh;
   assign stat.div_last = (dcnt_ff == DCW'(DIV_STEPS - 1));
   assign br_sh = {br_ff[CW-1:0], bq_ff[SW-1]};
   assign pr_sh = {pr_ff[CW-1:0], pq_ff[SW-1]};

   // pushed sums
   logic [15:0] bold, pold;
   logic [SW-1:0] bsum_n, psum_n;
   assign bold = (bcnt_ff < DEPTH_C) ? 16'd0 : bwin_ff[bpos_ff];
   assign pold = (pcnt_ff < DEPTH_C) ? 16'd0 : pwin_ff[ppos_ff];
   assign bsum_n = bsum_ff - SW'(bold) + SW'(smp_ff);
   assign psum_n = psum_ff - SW'(pold) + SW'(smp_ff);

   logic [15:0] bavg, pavg;
   assign bavg = (bcnt_ff == '0) ? 16'd0 : bq_ff[15:0];
   assign pavg = (pcnt_ff == '0) ? 16'd0 : pq_ff[15:0];

   logic touched;
   assign touched = stat.ppush_ok && (bavg > pavg) && ((bavg - pavg) > sens_ff);

   // baseline avg must track sum even when no divide runs: keep quotient live
   always_ff @(posedge clock) begin
      if (reset) begin
         bq_ff <= '0;
      end else if (cmd.div_start) begin
         bq_ff <= cmd.bpush ? bsum_n : bsum_ff;
         br_ff <= '0;
      end else if (cmd.div_step) begin
         if (br_sh >= {1'b0, bcnt_ff} && bcnt_ff != '0) begin
            br_ff <= br_sh - {1'b0, bcnt_ff};
            bq_ff <= {bq_ff[SW-2:0], 1'b1};
         end else begin
            br_ff <= br_sh;
            bq_ff <= {bq_ff[SW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         pq_ff <= cmd.ppush ? psum_n : psum_ff;
         pr_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (pr_sh >= {1'b0, pcnt_ff} && pcnt_ff != '0) begin
            pr_ff <= pr_sh - {1'b0, pcnt_ff};
            pq_ff <= {pq_ff[SW-2:0], 1'b1};
         end else begin
            pr_ff <= pr_sh;
            pq_ff <= {pq_ff[SW-2:0], 1'b0};
         end
      end
   end

   // windows
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) bwin_ff[i] <= '0;
      end else if (cmd.bpush) begin
         bwin_ff[bpos_ff] <= smp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy) pwin_ff[cpos_ff] <= bwin_ff[cpos_ff];
      else if (cmd.ppush) pwin_ff[ppos_ff] <= smp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) cpos_ff <= '0;
      else if (cmd.copy) cpos_ff <= (cpos_ff == POS_MAX) ? '0 : cpos_ff + 1'b1;
   end

   // window bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         bsum_ff <= '0; bcnt_ff <= '0; bpos_ff <= '0;
         psum_ff <= '0; pcnt_ff <= '0; ppos_ff <= '0;
      end else begin
         if (cmd.bpush) begin
            bsum_ff <= bsum_n;
            if (bcnt_ff < DEPTH_C) bcnt_ff <= bcnt_ff + 1'b1;
            bpos_ff <= (bpos_ff == POS_MAX) ? '0 : bpos_ff + 1'b1;
         end
         if (cmd.ppush) begin
            psum_ff <= psum_n;
            if (pcnt_ff < DEPTH_C) pcnt_ff <= pcnt_ff + 1'b1;
            ppos_ff <= (ppos_ff == POS_MAX) ? '0 : ppos_ff + 1'b1;
         end
         if (cmd.finish && op_ff == tdma_pkg::OP_START && err == tdma_pkg::ERR_OK) begin
            psum_ff <= bsum_ff;
            pcnt_ff <= bcnt_ff;
            ppos_ff <= PW'(bcnt_ff % DEPTH);
         end
      end
   end

   // session control and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         brun_ff <= 1'b1; active_ff <= 1'b0; trig_ff <= 1'b0; pwr_ff <= 1'b0;
         ticks_ff <= '0; hold_ff <= '0;
         rsp_session_done <= 1'b0; rsp_touch_found <= 1'b0;
         rsp_last_value <= '0; rsp_start_error <= '0;
      end else if (cmd.finish) begin
         rsp_session_done <= 1'b0;
         rsp_touch_found <= 1'b0;
         rsp_last_value <= '0;
         rsp_start_error <= '0;
         case (op_ff)
            tdma_pkg::OP_START: begin
               rsp_start_error <= err;
               if (err == tdma_pkg::ERR_OK) begin
                  active_ff <= 1'b1;
                  pwr_ff <= 1'b1;
                  ticks_ff <= tmo_ff;
                  hold_ff <= '0;
               end
            end
            tdma_pkg::OP_RESUME: brun_ff <= 1'b1;
            tdma_pkg::OP_SAMPLE: begin
               if (brun_ff && active_ff) brun_ff <= 1'b0;
               if (sess) begin
                  if (stat.ppush_ok) rsp_last_value <= pavg;
                  if (touched) trig_ff <= 1'b1;
                  if (touched || ticks_ff == 32'd1) begin
                     ticks_ff <= '0;
                     rsp_session_done <= 1'b1;
                     rsp_touch_found <= touched;
                     pwr_ff <= 1'b0;
                     if (touched) hold_ff <= hold_cfg_ff;
                     else active_ff <= 1'b0;
                  end else begin
                     ticks_ff <= ticks_ff - 1'b1;
                  end
               end else if (active_ff) begin
                  if (hold_ff <= 16'd1) begin
                     hold_ff <= '0;
                     trig_ff <= 1'b0;
                     active_ff <= 1'b0;
                  end else begin
                     hold_ff <= hold_ff - 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_trigger = trig_ff;
   assign rsp_power_enable = pwr_ff;
   assign rsp_session_active = active_ff;
   assign rsp_baseline_avg = bavg;

`ifndef ASSERT_OFF
   a_pwr_active: assert property (@(posedge clock) disable iff (reset)
      pwr_ff |-> active_ff) else $error("power without session");
   a_trig_active: assert property (@(posedge clock) disable iff (reset)
      trig_ff |-> active_ff) else $error("trigger without session");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      bcnt_ff <= DEPTH_C && pcnt_ff <= DEPTH_C) else $error("count overflow");
`endif

endmodule

// ----- tb/tb_touch_detect_moving_average_core.sv -----
`timescale 1ns / 100ps

module tb_touch_detect_moving_average_core;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DEPTH = tdma_pkg::WINDOW_DEPTH;

   typedef struct packed {
      logic        trigger;
      logic        power;
      logic        active;
      logic        done;
      logic        found;
      logic [15:0] last;
      logic [15:0] avg;
      logic [1:0]  err;
   } status_type;

   // directed row: either a register write or a word, optionally with a typed result
   typedef struct {
      bit          is_csr;
      logic [1:0]  index;
      logic [31:0] data;
      logic [1:0]  op;
      logic        rdy;
      logic [15:0] sample;
      bit          typed;
      logic [1:0]  exp_err;
      logic [15:0] exp_avg;
   } row_type;

   typedef struct {
      bit         typed;
      status_type res;
   } tag_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = tdma_pkg::OP_SAMPLE;
   logic        req_data_ready = 1'b0;
   logic [15:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_trigger;
   logic        rsp_power_enable;
   logic        rsp_session_active;
   logic        rsp_session_done;
   logic        rsp_touch_found;
   logic [15:0] rsp_last_value;
   logic [15:0] rsp_baseline_avg;
   logic [1:0]  rsp_start_error;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   touch_detect_moving_average_core dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state: window 0 is the baseline, window 1 the probe
   logic [15:0] win_cell [2][DEPTH];
   logic [19:0] win_sum [2];
   int          win_cnt [2];
   int          win_pos [2];
   logic        avg_running;
   logic [31:0] ticks_left;
   logic [31:0] hold_left;
   logic        sess_active, trig_level, pwr_level;
   logic [15:0] cfg_sens;
   logic [31:0] cfg_tmo;
   logic [15:0] cfg_hold;

   status_type expected_status [$];
   tag_type    word_tags [$];
   row_type    directed [$];

   int errors = 0;
   int cycles = 0;
   int words_sent = 0;
   int sessions = 0;
   int touches = 0;
   int rejects = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   function automatic void win_push(int w, logic [15:0] v);
      int p;
      p = win_pos[w] % DEPTH;
      if (win_cnt[w] < DEPTH) win_cnt[w]++;
      else win_sum[w] = win_sum[w] - 20'(win_cell[w][p]);
      win_cell[w][p] = v;
      win_sum[w] = win_sum[w] + 20'(v);
      win_pos[w] = (p + 1) % DEPTH;
   endfunction

   function automatic logic [15:0] win_avg(int w);
      logic [31:0] q;
      if (win_cnt[w] == 0) return '0;
      q = 32'(win_sum[w]) / 32'(win_cnt[w]);
      return q[15:0];
   endfunction

   // next touch status for one accepted word
   function automatic status_type touch_status(logic [1:0] op, logic rdy, logic [15:0] s);
      status_type r;
      logic touched;
      logic [15:0] b, p;
      r = '0;
      touched = 1'b0;
      case (op)
         tdma_pkg::OP_START: begin
            if (cfg_tmo == 0) r.err = tdma_pkg::ERR_TMO;
            else if (cfg_sens == 0) r.err = tdma_pkg::ERR_SENS;
            else if (sess_active) r.err = tdma_pkg::ERR_ACTIVE;
            else begin
               sess_active = 1'b1;
               pwr_level = 1'b1;
               ticks_left = cfg_tmo;
               hold_left = 0;
               win_cell[1] = win_cell[0];
               win_sum[1] = win_sum[0];
               win_cnt[1] = win_cnt[0];
               win_pos[1] = win_cnt[0] % DEPTH;
               sessions++;
            end
            if (r.err != tdma_pkg::ERR_OK) rejects++;
         end
         tdma_pkg::OP_RESUME: avg_running = 1'b1;
         tdma_pkg::OP_SAMPLE: begin
            if (avg_running) begin
               if (sess_active) avg_running = 1'b0;
               else if (rdy) win_push(0, s);
            end
            if (sess_active && ticks_left != 0) begin
               if (rdy) begin
                  win_push(1, s);
                  b = win_avg(0);
                  p = win_avg(1);
                  r.last = p;
                  if (b > p && (b - p) > cfg_sens) begin
                     trig_level = 1'b1;
                     ticks_left = 1;
                     touched = 1'b1;
                     touches++;
                  end
               end
               ticks_left--;
               if (ticks_left == 0) begin
                  r.done = 1'b1;
                  r.found = touched;
                  pwr_level = 1'b0;
                  if (touched) hold_left = 32'(cfg_hold);
                  else sess_active = 1'b0;
               end
            end else if (sess_active) begin
               if (hold_left <= 1) begin
                  hold_left = 0;
                  trig_level = 1'b0;
                  sess_active = 1'b0;
               end else begin
                  hold_left--;
               end
            end
         end
         default: ;
      endcase
      r.trigger = trig_level;
      r.power = pwr_level;
      r.active = sess_active;
      r.avg = win_avg(0);
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
         errors++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, got_v);
      end
   endtask

   // word monitor: predict on accept, compare on result
   always @(posedge clock) begin
      tag_type t;
      status_type e, g;
      cycles++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            t = word_tags.pop_front();
            e = touch_status(req_op, req_data_ready, req_sample);
            expected_status.push_back(t.typed ? t.res : e);
         end
         if (rsp_valid && rsp_ready) begin
            g = '{rsp_trigger, rsp_power_enable, rsp_session_active, rsp_session_done,
                  rsp_touch_found, rsp_last_value, rsp_baseline_avg, rsp_start_error};
            if (expected_status.size() == 0) begin
               errors++;
               $display("%0t unexpected result word %h", $time, g);
            end else begin
               e = expected_status.pop_front();
               check_field("trigger", 16'(e.trigger), 16'(g.trigger));
               check_field("power_enable", 16'(e.power), 16'(g.power));
               check_field("session_active", 16'(e.active), 16'(g.active));
               check_field("session_done", 16'(e.done), 16'(g.done));
               check_field("touch_found", 16'(e.found), 16'(g.found));
               check_field("last_value", e.last, g.last);
               check_field("baseline_avg", e.avg, g.avg);
               check_field("start_error", 16'(e.err), 16'(g.err));
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] op, logic rdy, logic [15:0] s,
                            bit typed = 0, status_type res = '0);
      tag_type t;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      t.typed = typed;
      t.res = res;
      word_tags.push_back(t);
      req_valid <= 1'b1;
      req_op <= op;
      req_data_ready <= rdy;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      if (op != tdma_pkg::OP_UNUSED) words_sent++;
   endtask

   // hold the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status.size() != 0 || word_tags.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic program_reg(logic [1:0] index, logic [31:0] data);
      drain();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         tdma_pkg::CSR_SENS: cfg_sens = data[15:0];
         tdma_pkg::CSR_TMO:  cfg_tmo = data;
         tdma_pkg::CSR_HOLD: cfg_hold = data[15:0];
         default: ;
      endcase
   endtask

   function automatic void add_csr(logic [1:0] index, logic [31:0] data);
      row_type r;
      r = '{default: '0};
      r.is_csr = 1;
      r.index = index;
      r.data = data;
      directed.push_back(r);
   endfunction

   function automatic void add_word(logic [1:0] op, logic rdy, logic [15:0] s,
                                    bit typed = 0, logic [1:0] err = tdma_pkg::ERR_OK,
                                    logic [15:0] avg = '0);
      row_type r;
      r = '{default: '0};
      r.op = op;
      r.rdy = rdy;
      r.sample = s;
      r.typed = typed;
      r.exp_err = err;
      r.exp_avg = avg;
      directed.push_back(r);
   endfunction

   function automatic logic [15:0] near(logic [15:0] lvl);
      return lvl ^ 16'($urandom_range(0, 255));
   endfunction

   // one touch session: baseline, start, probe ticks, hold, resume
   task automatic run_session();
      logic [15:0] lvl;
      bit press;
      lvl = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(4096, 65535));
      repeat ($urandom_range(0, 18))
         send_word(tdma_pkg::OP_SAMPLE, $urandom_range(9) != 0,
                   $urandom_range(7) == 0 ? 16'($urandom) : near(lvl));
      send_word(tdma_pkg::OP_START, 1'($urandom), 16'($urandom));
      if ($urandom_range(9) == 0)
         send_word(tdma_pkg::OP_START, 1'($urandom), 16'($urandom));
      press = 1'($urandom_range(1));
      repeat ($urandom_range(1, 24))
         send_word(tdma_pkg::OP_SAMPLE, $urandom_range(5) != 0,
                   press ? 16'($urandom_range(0, lvl / 2)) : near(lvl));
      repeat ($urandom_range(0, 6))
         send_word(tdma_pkg::OP_SAMPLE, 1'($urandom), 16'($urandom));
      if ($urandom_range(4) != 0)
         send_word(tdma_pkg::OP_RESUME, 1'($urandom), 16'($urandom));
   endtask

   task automatic run_phase(int n_words, int tx_pct, int rx_pct,
                            logic [31:0] sens, logic [31:0] tmo, logic [31:0] hold);
      int stop_at;
      int bursts;
      program_reg(tdma_pkg::CSR_SENS, sens);
      program_reg(tdma_pkg::CSR_TMO, tmo);
      program_reg(tdma_pkg::CSR_HOLD, hold);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      stop_at = words_sent + n_words;
      bursts = 0;
      while (words_sent < stop_at) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8))
               send_word(2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom));
         end else begin
            run_session();
         end
         bursts++;
         if (bursts % 20 == 0) drain();
      end
   endtask

   initial begin
      row_type r;
      status_type res;
      sens_init : begin
         cfg_sens = 0;
         cfg_tmo = 0;
         cfg_hold = 1;
         win_cell = '{default: '{default: '0}};
         win_sum = '{default: '0};
         win_cnt = '{default: 0};
         win_pos = '{default: 0};
         avg_running = 1'b1;
         ticks_left = 0;
         hold_left = 0;
         sess_active = 1'b0;
         trig_level = 1'b0;
         pwr_level = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset levels, start rejects, extremes, one touch session
      add_word(tdma_pkg::OP_SAMPLE, 0, 16'h0000, 1, tdma_pkg::ERR_OK, 16'h0000);
      add_word(tdma_pkg::OP_START, 1, 16'hFFFF, 1, tdma_pkg::ERR_TMO, 16'h0000);
      add_word(tdma_pkg::OP_UNUSED, 1, 16'hFFFF, 1, tdma_pkg::ERR_OK, 16'h0000);
      add_word(tdma_pkg::OP_RESUME, 0, 16'h0000, 1, tdma_pkg::ERR_OK, 16'h0000);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'hFFFF, 1, tdma_pkg::ERR_OK, 16'hFFFF);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'h0000, 1, tdma_pkg::ERR_OK, 16'h7FFF);
      add_csr(tdma_pkg::CSR_TMO, 32'd6);
      add_word(tdma_pkg::OP_START, 0, 16'h0000, 1, tdma_pkg::ERR_SENS, 16'h7FFF);
      add_csr(tdma_pkg::CSR_SENS, 32'h0001_0001);
      add_csr(tdma_pkg::CSR_HOLD, 32'd0);
      add_csr(tdma_pkg::CSR_UNUSED, 32'hFFFF_FFFF);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'h8000);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'h8000);
      add_word(tdma_pkg::OP_START, 0, 16'h0000);
      add_word(tdma_pkg::OP_START, 0, 16'h0000);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'h8000);
      add_word(tdma_pkg::OP_SAMPLE, 0, 16'h1234);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'h0000);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'h0000);
      add_word(tdma_pkg::OP_RESUME, 0, 16'h0000);
      add_csr(tdma_pkg::CSR_SENS, 32'h0000_FFFF);
      add_csr(tdma_pkg::CSR_TMO, 32'hFFFF_FFFF);
      add_csr(tdma_pkg::CSR_HOLD, 32'h0000_FFFF);
      add_word(tdma_pkg::OP_START, 1, 16'h5555);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'h0000);
      add_word(tdma_pkg::OP_SAMPLE, 1, 16'hFFFF);
      add_word(tdma_pkg::OP_START, 0, 16'hAAAA);
      add_word(tdma_pkg::OP_SAMPLE, 0, 16'h0000);
      foreach (directed[i]) begin
         r = directed[i];
         if (r.is_csr) begin
            program_reg(r.index, r.data);
         end else begin
            res = '0;
            res.err = r.exp_err;
            res.avg = r.exp_avg;
            send_word(r.op, r.rdy, r.sample, r.typed, res);
         end
      end

      // random sessions under three stall patterns
      run_phase(450, 13, 64, $urandom_range(1, 2000), $urandom_range(1, 30),
                $urandom_range(1, 5));
      run_phase(450, 64, 13, 1, $urandom_range(1, 12), 0);
      run_phase(450, 0, 0, $urandom_range(1, 8000), $urandom_range(1, 20),
                $urandom_range(2, 8));

      drain();
      $display("ran %0d words: %0d sessions started, %0d touches, %0d starts rejected",
               words_sent, sessions, touches, rejects);
      $display("register extremes and sender/receiver stall mixes covered");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
